[design/sss_pkg.sv]
// Shared types and constants for the streaming substring search.
// Used by every module of the block and by its checker; depends on nothing.
`timescale 1ns / 1ps

package sss_pkg;

    // Sizing of the search.
    localparam int MAX_NEEDLE     = 32;
    localparam int POSITION_WIDTH = 16;

    // Fixed by the configuration register map.
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 3;
    localparam int NEEDLE_REGS   = 4;
    localparam int NEEDLE_BYTES  = NEEDLE_REGS * (CFG_DATA_W / 8);
    localparam int NB_IDX_W      = $clog2(NEEDLE_BYTES);
    localparam int NLEN_W        = 6;

    // Derived widths.
    localparam int LEN_W     = $clog2(MAX_NEEDLE + 1);
    localparam int WIDE_W    = (LEN_W > NLEN_W) ? LEN_W : NLEN_W;
    localparam int WIN_DEPTH = (MAX_NEEDLE > 1) ? MAX_NEEDLE - 1 : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_LOW    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_SECOND = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_THIRD  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_HIGH   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_LENGTH = 3'd4;

    typedef struct packed {
        logic [7:0] haystack_byte;
        logic       last;
    } haystack_t;

    typedef struct packed {
        logic                      found;
        logic [POSITION_WIDTH-1:0] position;
        logic                      position_saturated;
    } result_t;

    // One classified beat as it travels from the front to the back.
    typedef struct packed {
        logic [7:0] hay_byte;
        logic       last;
        logic       term;
    } entry_t;

    // Needle reversed so that element j lines up with the byte j places back.
    typedef struct packed {
        logic [MAX_NEEDLE-1:0][7:0] pattern;
        logic [MAX_NEEDLE-1:0]      mask;
        logic [LEN_W-1:0]           len;
    } needle_t;

endpackage

[design/sss_needle.sv]
// Configuration registers of the needle and the registered, aligned copy
// that the compare uses. Depends on sss_pkg.
`timescale 1ns / 1ps

module sss_needle (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [sss_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sss_pkg::CFG_DATA_W-1:0]     cfg_data,
    output sss_pkg::needle_t                   needle
);
    import sss_pkg::*;

    logic [NEEDLE_REGS-1:0][CFG_DATA_W-1:0] needle_reg;
    logic [NLEN_W-1:0]                      length_reg;
    logic [NEEDLE_BYTES-1:0][7:0]           needle_bytes;
    logic [WIDE_W-1:0]                      len_wide;
    logic [LEN_W-1:0]                       len_eff;
    needle_t                                aligned_next;
    needle_t                                aligned_reg;

    assign needle_bytes = needle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_reg <= '0;
            length_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_NEEDLE_LOW:    needle_reg[0] <= cfg_data;
                CFG_NEEDLE_SECOND: needle_reg[1] <= cfg_data;
                CFG_NEEDLE_THIRD:  needle_reg[2] <= cfg_data;
                CFG_NEEDLE_HIGH:   needle_reg[3] <= cfg_data;
                CFG_NEEDLE_LENGTH: length_reg    <= cfg_data[NLEN_W-1:0];
                default:           ;
            endcase
        end
    end

    // Lengths above the window size are clamped to it.
    always_comb
    begin
        logic [WIDE_W-1:0] idx;
        idx = '0;
        if (WIDE_W'(length_reg) > WIDE_W'(MAX_NEEDLE))
            len_wide = WIDE_W'(MAX_NEEDLE);
        else
            len_wide = WIDE_W'(length_reg);
        len_eff = len_wide[LEN_W-1:0];

        aligned_next.len = len_eff;
        for (int j = 0; j < MAX_NEEDLE; j++)
        begin
            idx = len_wide - WIDE_W'(1) - WIDE_W'(j);
            aligned_next.mask[j]    = (WIDE_W'(j) < len_wide);
            aligned_next.pattern[j] = 8'h00;
            if (aligned_next.mask[j] && (idx < WIDE_W'(NEEDLE_BYTES)))
                aligned_next.pattern[j] = needle_bytes[idx[NB_IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            aligned_reg <= '0;
        else
            aligned_reg <= aligned_next;
    end

    assign needle = aligned_reg;

endmodule

[design/sss_front.sv]
// Input stage: takes haystack beats, marks terminators and hands them to the
// queue. Depends on sss_pkg.
`timescale 1ns / 1ps

module sss_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                haystack_valid,
    output logic                haystack_stall,
    input  sss_pkg::haystack_t  haystack,
    input  logic                queue_full,
    output logic                push,
    output sss_pkg::entry_t     push_entry
);
    import sss_pkg::*;

    logic   front_valid_reg;
    entry_t front_entry_reg;
    logic   accept;

    assign haystack_stall = front_valid_reg && queue_full;
    assign accept         = haystack_valid && !haystack_stall;
    assign push           = front_valid_reg && !queue_full;
    assign push_entry     = front_entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else if (accept)
            front_valid_reg <= 1'b1;
        else if (push)
            front_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_entry_reg.hay_byte <= haystack.haystack_byte;
            front_entry_reg.last     <= haystack.last;
            front_entry_reg.term     <= (haystack.haystack_byte == 8'h00);
        end
    end

endmodule

[design/sss_queue.sv]
// Short queue between the front and the search engine.
// Depends on sss_pkg.
`timescale 1ns / 1ps

module sss_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sss_pkg::entry_t push_entry,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output sss_pkg::entry_t head
);
    import sss_pkg::*;

    entry_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

[design/sss_back.sv]
// Search engine: sliding window, parallel compare, byte counter and the
// result register. Depends on sss_pkg.
`timescale 1ns / 1ps

module sss_back (
    input  logic             clk,
    input  logic             rst_n,
    input  sss_pkg::needle_t needle,
    input  logic             empty,
    input  sss_pkg::entry_t  head,
    output logic             pop,
    output logic             result_valid,
    input  logic             result_stall,
    output sss_pkg::result_t result
);
    import sss_pkg::*;

    localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

    logic [7:0]                window_reg [WIN_DEPTH];
    logic [LEN_W-1:0]          fill_reg;
    logic [POSITION_WIDTH-1:0] index_reg;
    logic                      saturated_reg;
    logic                      decided_reg;
    logic                      result_valid_reg;
    result_t                   result_reg;

    logic [LEN_W-1:0]          fill_next;
    logic                      empty_needle;
    logic                      searching;
    logic                      match;
    logic                      emit;
    result_t                   result_next;

    assign pop          = !empty && (!result_valid_reg || !result_stall);
    assign empty_needle = (needle.len == '0);
    // A byte that moves the window: live search, real needle, not a terminator.
    assign searching    = !decided_reg && !empty_needle && !head.term;
    assign fill_next    = (fill_reg < LEN_W'(MAX_NEEDLE)) ? fill_reg + 1'b1 : fill_reg;

    always_comb
    begin
        logic [7:0] hist;
        hist  = 8'h00;
        match = (fill_next >= needle.len);
        for (int j = 0; j < MAX_NEEDLE; j++)
        begin
            if (j == 0)
                hist = head.hay_byte;
            else
                hist = window_reg[(j > 0) ? j - 1 : 0];
            if (needle.mask[j] && (needle.pattern[j] != hist))
                match = 1'b0;
        end
    end

    always_comb
    begin
        result_next = '0;
        emit        = 1'b0;
        if (!decided_reg)
        begin
            if (empty_needle)
            begin
                emit              = 1'b1;
                result_next.found = 1'b1;
            end
            else if (head.term)
                emit = 1'b1;
            else if (match)
            begin
                emit              = 1'b1;
                result_next.found = 1'b1;
                if (saturated_reg)
                begin
                    result_next.position           = POS_MAX;
                    result_next.position_saturated = 1'b1;
                end
                else
                    result_next.position = index_reg
                                         - POSITION_WIDTH'(needle.len - LEN_W'(1));
            end
            else if (head.last)
                emit = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg         <= '0;
            index_reg        <= '0;
            saturated_reg    <= 1'b0;
            decided_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (head.last)
                begin
                    fill_reg      <= '0;
                    index_reg     <= '0;
                    saturated_reg <= 1'b0;
                    decided_reg   <= 1'b0;
                end
                else
                begin
                    if (emit)
                        decided_reg <= 1'b1;
                    if (searching)
                    begin
                        fill_reg <= fill_next;
                        if (index_reg == POS_MAX)
                            saturated_reg <= 1'b1;
                        else
                            index_reg <= index_reg + 1'b1;
                    end
                end
            end
            if (pop && emit)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // Window contents past the fill count never decide a match, so no clearing.
    always_ff @(posedge clk)
    begin
        if (pop && searching)
        begin
            window_reg[0] <= head.hay_byte;
            for (int i = 1; i < WIN_DEPTH; i++)
                window_reg[i] <= window_reg[i - 1];
        end
        if (pop && emit)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[design/substring_search_stream.sv]
// Top level of the streaming first-occurrence substring search.
// Instantiates sss_needle, sss_front, sss_queue and sss_back; uses sss_pkg.
//
//  Channel    Handshake                Content of one beat
//  ---------  -----------------------  -----------------------------------------
//  haystack   haystack_valid / _stall  haystack_byte, last
//  result     result_valid / _stall    found, position, position_saturated
//  config     cfg_valid / cfg_ready    cfg_index (0..4), cfg_data (64 bits)
//
// One haystack byte is taken per clock cycle when the result side keeps up; a
// deciding byte reaches the result through the front register, a queue slot
// and the result register. The compare of the whole 32-byte window against
// the pre-aligned needle is combinational. Reset (rst_n low, asynchronous)
// clears the search state and all configuration to zero. A stall on the
// result side fills the two-entry queue and then backs up into haystack_stall.
// Configuration takes effect from the aligned copy; cfg_ready is always high.
`timescale 1ns / 1ps

module substring_search_stream (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             haystack_valid,
    output logic                             haystack_stall,
    input  sss_pkg::haystack_t               haystack,
    output logic                             result_valid,
    input  logic                             result_stall,
    output sss_pkg::result_t                 result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sss_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sss_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sss_pkg::*;

    needle_t needle;
    entry_t  push_entry;
    entry_t  head;
    logic    push;
    logic    pop;
    logic    queue_full;
    logic    queue_empty;

    // Register writes are always taken in the same cycle.
    assign cfg_ready = 1'b1;

    // Needle registers and the aligned copy that the compare sees.
    sss_needle u_needle (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .needle    (needle)
    );

    // Front: accepts a beat and flags the terminator byte.
    sss_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .haystack_valid (haystack_valid),
        .haystack_stall (haystack_stall),
        .haystack       (haystack),
        .queue_full     (queue_full),
        .push           (push),
        .push_entry     (push_entry)
    );

    // The queue lets the front keep taking beats while a result waits.
    sss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .empty      (queue_empty),
        .head       (head)
    );

    // Back: window, compare, byte counter and the result register.
    sss_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .needle       (needle),
        .empty        (queue_empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[design/sss_checker.sv]
// Port-level checks of the substring search and their binding to the top
// level. Depends on sss_pkg and substring_search_stream.
`timescale 1ns / 1ps

module sss_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             result_valid,
    input logic                             result_stall,
    input sss_pkg::result_t                 result,
    input logic                             cfg_valid,
    input logic                             cfg_ready
);
    import sss_pkg::*;

    // A stalled result beat stays and keeps its value.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // A miss carries a zero position and no saturation flag.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.found |->
            result.position == '0 && !result.position_saturated)
        else $error("miss with non-zero position fields");

    // A saturated position is only given with a match, clamped at the maximum.
    a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.position_saturated |->
            result.found && result.position == '1)
        else $error("saturated position not clamped");

    // The register port never holds a write back.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write not taken");

endmodule

bind substring_search_stream sss_checker u_sss_checker (.*);
